### rtl/poc_pkg.sv
// Shared types, widths and helpers for the point obstacle clearance unit.
// Used by every module in rtl/; depends on nothing else.
`default_nettype none

package poc_pkg;

    localparam int COORD_W = 16;   // signed Q8.8 coordinate
    localparam int MAG_W   = 17;   // magnitude of a coordinate difference
    localparam int LEN_W   = 34;   // squared lengths, Q18.16
    localparam int PROD_W  = LEN_W + MAG_W;
    localparam int RAD_W   = 15;   // robot radius, unsigned Q7.8
    localparam int OUT_W   = 18;   // clearance output
    localparam int CLR_W   = OUT_W + 1;
    localparam int STEPS   = 17;   // one bit or one root digit per cycle
    localparam int CNT_W   = 5;
    localparam int ROOT_W  = LEN_W / 2;
    localparam int REM_W   = ROOT_W + 2;

    localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(64);

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t query_x;
        coord_t query_y;
        coord_t edge_ax;
        coord_t edge_ay;
        coord_t edge_bx;
        coord_t edge_by;
        logic   last_edge;
    } edge_beat_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] min_clearance;
        logic                    collision;
    } result_beat_t;

    // Load starts a unit on new operands, step advances it by one bit.
    typedef struct packed {
        logic load;
        logic step;
    } unit_ctrl_t;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_LEN   = 11'b000_0000_0010,
        S_DOT   = 11'b000_0000_0100,
        S_PROJ  = 11'b000_0000_1000,
        S_SCALE = 11'b000_0001_0000,
        S_DIV   = 11'b000_0010_0000,
        S_ADJ   = 11'b000_0100_0000,
        S_DIST  = 11'b000_1000_0000,
        S_SQRT  = 11'b001_0000_0000,
        S_CHK   = 11'b010_0000_0000,
        S_FIN   = 11'b100_0000_0000
    } state_t;

    function automatic logic [MAG_W-1:0] mag17(input logic signed [MAG_W:0] v);
        logic signed [MAG_W:0] n;
        n = -v;
        return v[MAG_W] ? n[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/point_obstacle_clearance_unit.sv
// Top level of the point obstacle clearance unit: sequencer, square root, state.
// Depends on poc_pkg, poc_mul and poc_div.
//
//   channel   | dir | handshake               | beat
//   ----------+-----+-------------------------+---------------------------
//   edge      | in  | edge_valid/edge_ready   | edge_beat   (query point, edge)
//   result    | out | result_valid/result_ready | result_beat (clearance)
//   radius    | in  | radius_we (no wait)     | radius_wdata
//
// An edge runs the 17-step serial multiplier pair, the serial divider pair
// and the serial square root in turn; the scaling multiply and the dividers
// run only when its projection lands inside the segment, not on a clamp.
// Once a query has collided, its remaining edges skip straight to S_FIN.
// Reset clears the query state and loads the radius with its default.
// A finished result waits in its own register, so the next edge is taken
// while it is unread; only a second last edge stalls until it drains.
`default_nettype none

module point_obstacle_clearance_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         edge_valid,
    output logic                              edge_ready,
    input  wire poc_pkg::edge_beat_t          edge_beat,
    output logic                              result_valid,
    input  wire logic                         result_ready,
    output poc_pkg::result_beat_t             result_beat,
    input  wire logic                         radius_we,
    input  wire logic [poc_pkg::RAD_W-1:0]    radius_wdata
);

    localparam int MW = poc_pkg::MAG_W;
    localparam int LW = poc_pkg::LEN_W;
    localparam int PW = poc_pkg::PROD_W;
    localparam int CW = poc_pkg::CLR_W;
    localparam int RW = poc_pkg::ROOT_W;
    localparam int EW = poc_pkg::REM_W;

    // Control state.
    poc_pkg::state_t              state_reg, state_next;
    logic [poc_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [LW-1:0]                min_reg, min_next;
    logic                         frozen_reg, frozen_next;
    logic signed [CW-1:0]         frz_reg, frz_next;
    logic                         result_valid_reg, result_valid_next;
    logic [poc_pkg::RAD_W-1:0]    radius_reg, radius_next;

    // Working registers of the current edge.
    poc_pkg::coord_t              qx_reg, qy_reg, ax_reg, ay_reg;
    logic signed [MW-1:0]         dx_reg, dy_reg, vx_reg, vy_reg;
    logic                         last_reg;
    logic [LW-1:0]                len2_reg, len2_next;
    logic [LW-1:0]                t_reg, t_next;
    logic signed [MW-1:0]         px_reg, px_next, py_reg, py_next;
    logic [LW-1:0]                rad_reg, rad_next;
    logic [EW-1:0]                rem_reg, rem_next;
    logic [RW-1:0]                root_reg, root_next;
    logic signed [CW-1:0]         clr_reg, clr_next;
    poc_pkg::result_beat_t        result_reg, result_next;

    // Serial units.
    poc_pkg::unit_ctrl_t          mul_ctrl, div_ctrl;
    logic [LW-1:0]                mcand_x, mcand_y;
    logic [MW-1:0]                mplier_x, mplier_y;
    logic [PW-1:0]                prod_x, prod_y;
    logic [PW-1:0]                num_x, num_y;
    logic [MW-1:0]                quot_x, quot_y;

    logic                         accept;
    logic                         last_step;
    logic [MW-1:0]                dx_mag, dy_mag, vx_mag, vy_mag, ex_mag, ey_mag;
    logic signed [MW:0]           ex, ey;
    logic signed [LW+1:0]         t_x, t_y, t_sum;
    logic [LW-1:0]                len2_sum, d2;

    assign edge_ready   = state_reg == poc_pkg::S_IDLE;
    assign accept       = edge_valid && edge_ready;
    assign result_valid = result_valid_reg;
    assign result_beat  = result_reg;
    assign last_step    = cnt_reg == poc_pkg::CNT_W'(poc_pkg::STEPS);

    assign dx_mag = poc_pkg::mag17({dx_reg[MW-1], dx_reg});
    assign dy_mag = poc_pkg::mag17({dy_reg[MW-1], dy_reg});
    assign vx_mag = poc_pkg::mag17({vx_reg[MW-1], vx_reg});
    assign vy_mag = poc_pkg::mag17({vy_reg[MW-1], vy_reg});
    assign ex     = (MW+1)'(qx_reg) - (MW+1)'(px_reg);
    assign ey     = (MW+1)'(qy_reg) - (MW+1)'(py_reg);
    assign ex_mag = poc_pkg::mag17(ex);
    assign ey_mag = poc_pkg::mag17(ey);

    // Each dot-product term is below 2^32, so its low product bits suffice.
    assign t_x = (vx_reg[MW-1] ^ dx_reg[MW-1]) ? -$signed({2'b00, prod_x[LW-1:0]})
                                                :  $signed({2'b00, prod_x[LW-1:0]});
    assign t_y = (vy_reg[MW-1] ^ dy_reg[MW-1]) ? -$signed({2'b00, prod_y[LW-1:0]})
                                                :  $signed({2'b00, prod_y[LW-1:0]});
    assign t_sum    = t_x + t_y;
    assign len2_sum = prod_x[LW-1:0] + prod_y[LW-1:0];
    assign d2       = prod_x[LW-1:0] + prod_y[LW-1:0];

    // Rounding to nearest is folded into the dividend as half the divisor.
    assign num_x = prod_x + PW'(len2_reg >> 1);
    assign num_y = prod_y + PW'(len2_reg >> 1);

    always_comb
    begin
        mcand_x  = '0;
        mcand_y  = '0;
        mplier_x = '0;
        mplier_y = '0;
        case (state_reg)
            poc_pkg::S_LEN:
            begin
                mcand_x  = LW'(dx_mag);
                mplier_x = dx_mag;
                mcand_y  = LW'(dy_mag);
                mplier_y = dy_mag;
            end
            poc_pkg::S_DOT:
            begin
                mcand_x  = LW'(vx_mag);
                mplier_x = dx_mag;
                mcand_y  = LW'(vy_mag);
                mplier_y = dy_mag;
            end
            poc_pkg::S_SCALE:
            begin
                mcand_x  = t_reg;
                mplier_x = dx_mag;
                mcand_y  = t_reg;
                mplier_y = dy_mag;
            end
            poc_pkg::S_DIST:
            begin
                mcand_x  = LW'(ex_mag);
                mplier_x = ex_mag;
                mcand_y  = LW'(ey_mag);
                mplier_y = ey_mag;
            end
            default:
            begin
                mcand_x = '0;
            end
        endcase
    end

    always_comb
    begin
        logic mul_busy;
        mul_busy = state_reg == poc_pkg::S_LEN || state_reg == poc_pkg::S_DOT ||
                   state_reg == poc_pkg::S_SCALE || state_reg == poc_pkg::S_DIST;
        mul_ctrl.load = mul_busy && cnt_reg == '0;
        mul_ctrl.step = mul_busy && cnt_reg != '0;
        div_ctrl.load = state_reg == poc_pkg::S_DIV && cnt_reg == '0;
        div_ctrl.step = state_reg == poc_pkg::S_DIV && cnt_reg != '0;
    end

    poc_mul u_mul_x (
        .clk     (clk),
        .ctrl    (mul_ctrl),
        .mcand   (mcand_x),
        .mplier  (mplier_x),
        .product (prod_x)
    );

    poc_mul u_mul_y (
        .clk     (clk),
        .ctrl    (mul_ctrl),
        .mcand   (mcand_y),
        .mplier  (mplier_y),
        .product (prod_y)
    );

    poc_div u_div_x (
        .clk  (clk),
        .ctrl (div_ctrl),
        .num  (num_x),
        .den  (len2_reg),
        .quot (quot_x)
    );

    poc_div u_div_y (
        .clk  (clk),
        .ctrl (div_ctrl),
        .num  (num_y),
        .den  (len2_reg),
        .quot (quot_y)
    );

    // Sequencer and per-query state.
    always_comb
    begin
        logic [LW-1:0]         new_min;
        logic [EW+1:0]         rem_sh;
        logic [EW+1:0]         trial;
        logic [RW:0]           rounded;
        logic signed [MW:0]    adj_x, adj_y;
        logic                  slot_free;

        state_next        = state_reg;
        cnt_next          = '0;
        min_next          = min_reg;
        frozen_next       = frozen_reg;
        frz_next          = frz_reg;
        len2_next         = len2_reg;
        t_next            = t_reg;
        px_next           = px_reg;
        py_next           = py_reg;
        rad_next          = rad_reg;
        rem_next          = rem_reg;
        root_next         = root_reg;
        clr_next          = clr_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        radius_next       = radius_we ? radius_wdata : radius_reg;
        slot_free         = !result_valid_reg || result_ready;

        new_min = (d2 < min_reg) ? d2 : min_reg;
        rem_sh  = {rem_reg, rad_reg[LW-1:LW-2]};
        trial   = (EW+2)'({root_reg, 2'b01});
        rounded = {1'b0, root_reg} + ((rem_reg > EW'(root_reg)) ? (RW+1)'(1) : '0);
        adj_x   = (MW+1)'(ax_reg) + (dx_reg[MW-1] ? -$signed({1'b0, quot_x})
                                                  :  $signed({1'b0, quot_x}));
        adj_y   = (MW+1)'(ay_reg) + (dy_reg[MW-1] ? -$signed({1'b0, quot_y})
                                                  :  $signed({1'b0, quot_y}));

        unique case (state_reg)
            poc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = frozen_reg ? poc_pkg::S_FIN : poc_pkg::S_LEN;
                end
            end
            poc_pkg::S_LEN, poc_pkg::S_DOT, poc_pkg::S_SCALE, poc_pkg::S_DIV,
            poc_pkg::S_DIST, poc_pkg::S_SQRT:
            begin
                cnt_next = last_step ? '0 : cnt_reg + 1'b1;
                if (state_reg == poc_pkg::S_DOT && cnt_reg == '0)
                begin
                    len2_next = len2_sum;
                end
                if (state_reg == poc_pkg::S_SQRT)
                begin
                    if (cnt_reg == '0)
                    begin
                        min_next  = new_min;
                        rad_next  = new_min;
                        rem_next  = '0;
                        root_next = '0;
                    end
                    else
                    begin
                        // One root digit per cycle from two radicand bits.
                        if (rem_sh >= trial)
                        begin
                            rem_next  = EW'(rem_sh - trial);
                            root_next = {root_reg[RW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_next  = EW'(rem_sh);
                            root_next = {root_reg[RW-2:0], 1'b0};
                        end
                        rad_next = {rad_reg[LW-3:0], 2'b00};
                    end
                end
                if (last_step)
                begin
                    case (state_reg)
                        poc_pkg::S_LEN:   state_next = poc_pkg::S_DOT;
                        poc_pkg::S_DOT:   state_next = poc_pkg::S_PROJ;
                        poc_pkg::S_SCALE: state_next = poc_pkg::S_DIV;
                        poc_pkg::S_DIV:   state_next = poc_pkg::S_ADJ;
                        poc_pkg::S_DIST:  state_next = poc_pkg::S_SQRT;
                        default:          state_next = poc_pkg::S_CHK;
                    endcase
                end
            end
            poc_pkg::S_PROJ:
            begin
                // Clamp to the start when behind it or when the edge is a
                // single point, to the end when past it.
                if (len2_reg == '0 || t_sum <= 0)
                begin
                    px_next    = MW'(ax_reg);
                    py_next    = MW'(ay_reg);
                    state_next = poc_pkg::S_DIST;
                end
                else if (t_sum >= $signed({2'b00, len2_reg}))
                begin
                    px_next    = MW'(ax_reg) + dx_reg;
                    py_next    = MW'(ay_reg) + dy_reg;
                    state_next = poc_pkg::S_DIST;
                end
                else
                begin
                    t_next     = t_sum[LW-1:0];
                    state_next = poc_pkg::S_SCALE;
                end
            end
            poc_pkg::S_ADJ:
            begin
                px_next    = adj_x[MW-1:0];
                py_next    = adj_y[MW-1:0];
                state_next = poc_pkg::S_DIST;
            end
            poc_pkg::S_CHK:
            begin
                clr_next = $signed({1'b0, rounded}) - $signed(CW'(radius_reg));
                if ($signed({1'b0, rounded}) - $signed(CW'(radius_reg)) <= 0)
                begin
                    frozen_next = 1'b1;
                    frz_next    = $signed({1'b0, rounded}) - $signed(CW'(radius_reg));
                end
                state_next = poc_pkg::S_FIN;
            end
            poc_pkg::S_FIN:
            begin
                if (!last_reg)
                begin
                    state_next = poc_pkg::S_IDLE;
                end
                else if (slot_free)
                begin
                    result_next.min_clearance = frozen_reg ? frz_reg[poc_pkg::OUT_W-1:0]
                                                           : clr_reg[poc_pkg::OUT_W-1:0];
                    result_next.collision     = frozen_reg;
                    result_valid_next         = 1'b1;
                    min_next                  = '1;
                    frozen_next               = 1'b0;
                    frz_next                  = '0;
                    state_next                = poc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = poc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= poc_pkg::S_IDLE;
            cnt_reg          <= '0;
            min_reg          <= '1;
            frozen_reg       <= 1'b0;
            frz_reg          <= '0;
            result_valid_reg <= 1'b0;
            radius_reg       <= poc_pkg::RADIUS_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            min_reg          <= min_next;
            frozen_reg       <= frozen_next;
            frz_reg          <= frz_next;
            result_valid_reg <= result_valid_next;
            radius_reg       <= radius_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qx_reg   <= edge_beat.query_x;
            qy_reg   <= edge_beat.query_y;
            ax_reg   <= edge_beat.edge_ax;
            ay_reg   <= edge_beat.edge_ay;
            dx_reg   <= MW'(edge_beat.edge_bx) - MW'(edge_beat.edge_ax);
            dy_reg   <= MW'(edge_beat.edge_by) - MW'(edge_beat.edge_ay);
            vx_reg   <= MW'(edge_beat.query_x) - MW'(edge_beat.edge_ax);
            vy_reg   <= MW'(edge_beat.query_y) - MW'(edge_beat.edge_ay);
            last_reg <= edge_beat.last_edge;
        end
        len2_reg   <= len2_next;
        t_reg      <= t_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        rad_reg    <= rad_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        clr_reg    <= clr_next;
        result_reg <= result_next;
    end

    // A frozen query always holds a clearance of zero or below.
    assert property (@(posedge clk) disable iff (!rst_n)
        frozen_reg |-> frz_reg <= 0)
        else $error("frozen clearance is positive");

    // The interior projection is only entered with 0 < t < |d|^2.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == poc_pkg::S_SCALE |-> (t_reg != '0 && t_reg < len2_reg))
        else $error("projection parameter out of range");

    // An accepted edge always starts work.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != poc_pkg::S_IDLE)
        else $error("accepted edge dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

endmodule

`default_nettype wire

### rtl/poc_mul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per step.
// Depends on poc_pkg for widths and the control struct.
`default_nettype none

module poc_mul (
    input  wire logic                         clk,
    input  wire poc_pkg::unit_ctrl_t          ctrl,
    input  wire logic [poc_pkg::LEN_W-1:0]    mcand,
    input  wire logic [poc_pkg::MAG_W-1:0]    mplier,
    output logic      [poc_pkg::PROD_W-1:0]   product
);

    logic [poc_pkg::LEN_W-1:0] mc_reg;
    logic [poc_pkg::LEN_W-1:0] hi_reg;
    logic [poc_pkg::MAG_W-1:0] lo_reg;
    logic [poc_pkg::LEN_W:0]   sum;

    // The partial sum gains at most one bit before it shifts right.
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mc_reg} : '0);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            mc_reg <= mcand;
            hi_reg <= '0;
            lo_reg <= mplier;
        end
        else if (ctrl.step)
        begin
            hi_reg <= sum[poc_pkg::LEN_W:1];
            lo_reg <= {sum[0], lo_reg[poc_pkg::MAG_W-1:1]};
        end
    end

    assign product = {hi_reg, lo_reg};

endmodule

`default_nettype wire

### rtl/poc_div.sv
// Restoring divider producing one quotient bit per step.
// Depends on poc_pkg; the caller guarantees the quotient fits in MAG_W bits.
`default_nettype none

module poc_div (
    input  wire logic                         clk,
    input  wire poc_pkg::unit_ctrl_t          ctrl,
    input  wire logic [poc_pkg::PROD_W-1:0]   num,
    input  wire logic [poc_pkg::LEN_W-1:0]    den,
    output logic      [poc_pkg::MAG_W-1:0]    quot
);

    logic [poc_pkg::LEN_W-1:0] den_reg;
    logic [poc_pkg::LEN_W-1:0] rem_reg;
    logic [poc_pkg::MAG_W-1:0] shf_reg;
    logic [poc_pkg::LEN_W:0]   trial;
    logic [poc_pkg::LEN_W:0]   diff;
    logic                      ge;

    assign trial = {rem_reg, shf_reg[poc_pkg::MAG_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            den_reg <= den;
            rem_reg <= num[poc_pkg::PROD_W-1:poc_pkg::MAG_W];
            shf_reg <= num[poc_pkg::MAG_W-1:0];
        end
        else if (ctrl.step)
        begin
            // The low bits of the dividend shift out as quotient bits shift in.
            rem_reg <= ge ? diff[poc_pkg::LEN_W-1:0] : trial[poc_pkg::LEN_W-1:0];
            shf_reg <= {shf_reg[poc_pkg::MAG_W-2:0], ge};
        end
    end

    assign quot = shf_reg;

endmodule

`default_nettype wire

### verif/point_obstacle_clearance_unit_tb.sv
// Self-checking testbench for point_obstacle_clearance_unit: edge beats in,
// clearance results out, predicted in a scoreboard class and checked in order.
// Depends on poc_pkg and the RTL of the unit; needs no files.
`default_nettype none

module point_obstacle_clearance_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Settling time that covers the work still in flight after the last
    // expected result has arrived.
    localparam int SETTLE     = 300;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_SPAN  = 3000;

    // Running minimum of the squared distance per query, the freeze at
    // the first non-positive clearance, and the queue of pending results.
    class clearance_scoreboard;
        logic [poc_pkg::RAD_W-1:0] radius;
        longint unsigned           best_d2;
        bit                        frozen;
        longint                    frozen_clr;
        poc_pkg::result_beat_t     pending[$];
        int                        errors;
        int                        results_seen;
        int                        collisions_seen;

        function new();
            radius = poc_pkg::RADIUS_RESET;
            errors = 0;
            results_seen = 0;
            collisions_seen = 0;
            clear_query();
        endfunction

        function void clear_query();
            best_d2 = (64'd1 << poc_pkg::LEN_W) - 1;
            frozen = 0;
            frozen_clr = 0;
        endfunction

        // Square root rounded to nearest, digit by digit.
        function longint unsigned root_nearest(longint unsigned x);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x)
                b = b >> 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            if (x > r)
                r = r + 1;
            return r;
        endfunction

        // num / den rounded to nearest, ties away from zero; den is positive.
        function longint div_nearest(longint num, longint den);
            longint unsigned m;
            longint unsigned q;
            m = (num < 0) ? longint'(-num) : longint'(num);
            q = (m + den / 2) / den;
            return (num < 0) ? -longint'(q) : longint'(q);
        endfunction

        function void note_edge(poc_pkg::edge_beat_t e);
            longint qx, qy, ax, ay, bx, by;
            longint dx, dy, vx, vy, len2, t, px, py, ex, ey, clr;
            longint unsigned d2;
            poc_pkg::result_beat_t want;
            qx = e.query_x;
            qy = e.query_y;
            ax = e.edge_ax;
            ay = e.edge_ay;
            bx = e.edge_bx;
            by = e.edge_by;
            if (!frozen)
            begin
                dx = bx - ax;
                dy = by - ay;
                vx = qx - ax;
                vy = qy - ay;
                len2 = dx * dx + dy * dy;
                t = vx * dx + vy * dy;
                // Clamp the projection to the segment ends.
                if (len2 == 0 || t <= 0)
                begin
                    px = ax;
                    py = ay;
                end
                else if (t >= len2)
                begin
                    px = bx;
                    py = by;
                end
                else
                begin
                    px = ax + div_nearest(t * dx, len2);
                    py = ay + div_nearest(t * dy, len2);
                end
                ex = qx - px;
                ey = qy - py;
                d2 = longint'(ex * ex + ey * ey) & ((64'd1 << poc_pkg::LEN_W) - 1);
                if (d2 < best_d2)
                    best_d2 = d2;
                clr = longint'(root_nearest(best_d2)) - longint'(radius);
                if (clr <= 0)
                begin
                    frozen = 1;
                    frozen_clr = clr;
                end
            end
            if (e.last_edge)
            begin
                if (frozen)
                    clr = frozen_clr;
                else
                    clr = longint'(root_nearest(best_d2)) - longint'(radius);
                want.min_clearance = clr[poc_pkg::OUT_W-1:0];
                want.collision = (clr <= 0);
                pending.push_back(want);
                clear_query();
            end
        endfunction

        function void check_result(poc_pkg::result_beat_t got);
            poc_pkg::result_beat_t want;
            results_seen++;
            if (got.collision)
                collisions_seen++;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, actual clearance %0d collision %0b",
                         $time, got.min_clearance, got.collision);
                return;
            end
            want = pending.pop_front();
            if (got.min_clearance !== want.min_clearance)
            begin
                errors++;
                $display("%0t: min_clearance expected %0d actual %0d",
                         $time, want.min_clearance, got.min_clearance);
            end
            if (got.collision !== want.collision)
            begin
                errors++;
                $display("%0t: collision expected %0b actual %0b",
                         $time, want.collision, got.collision);
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      edge_valid;
    logic                      edge_ready;
    poc_pkg::edge_beat_t       edge_beat;
    logic                      result_valid;
    logic                      result_ready;
    poc_pkg::result_beat_t     result_beat;
    logic                      radius_we;
    logic [poc_pkg::RAD_W-1:0] radius_wdata;

    clearance_scoreboard sb;
    bit                  quiet;      // when set, neither side idles
    bit                  hold_off;   // receiver refuses results while set
    int                  edges_sent;
    int                  queries_sent;
    int                  idle_cycles;

    point_obstacle_clearance_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .edge_valid   (edge_valid),
        .edge_ready   (edge_ready),
        .edge_beat    (edge_beat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_beat  (result_beat),
        .radius_we    (radius_we),
        .radius_wdata (radius_wdata)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Watchdog: any run of cycles without a beat on either channel that
    // exceeds the limit means the block has hung.
    always @(posedge clk)
    begin
        if ((edge_valid && edge_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: a random wait before each result, longer while hold_off is
    // set. Ready is only lowered when a wait is due, so a back-to-back
    // accept never puts two assignments on it in one step.
    initial
    begin : receiver
        int n;
        result_ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            n = quiet ? 0 : $urandom_range(0, 3);
            if (n > 0 || hold_off)
            begin
                result_ready <= 1'b0;
                repeat (n) @(posedge clk);
                while (hold_off)
                    @(posedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_valid);
            sb.check_result(result_beat);
        end
    end

    // Offer one edge beat after a random gap and wait until it is taken.
    task automatic send_edge(poc_pkg::edge_beat_t b);
        int n;
        n = quiet ? 0 : $urandom_range(0, 3);
        if (n > 0)
        begin
            edge_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        edge_valid <= 1'b1;
        edge_beat  <= b;
        do
            @(posedge clk);
        while (!edge_ready);
        sb.note_edge(b);
        edges_sent++;
        if (b.last_edge)
            queries_sent++;
    endtask

    function automatic poc_pkg::edge_beat_t make_edge(int qx, int qy, int ax, int ay,
                                                      int bx, int by, bit last);
        poc_pkg::edge_beat_t e;
        e.query_x = poc_pkg::COORD_W'(qx);
        e.query_y = poc_pkg::COORD_W'(qy);
        e.edge_ax = poc_pkg::COORD_W'(ax);
        e.edge_ay = poc_pkg::COORD_W'(ay);
        e.edge_bx = poc_pkg::COORD_W'(bx);
        e.edge_by = poc_pkg::COORD_W'(by);
        e.last_edge = last;
        return e;
    endfunction

    // A coordinate near a center, saturated to the 16-bit range.
    function automatic int near_coord(int center, int span);
        int v;
        v = center + $signed($urandom_range(0, 2 * span)) - span;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v;
    endfunction

    // One query of n_edges edges. Close queries keep the vertices within 127 or
    // 1023 of the point on each axis, so collisions and freezes come up often.
    task automatic run_query(int n_edges);
        int qx, qy, span, ax, ay, bx, by;
        bit close;
        close = 1'($urandom_range(0, 1));
        qx = $signed(16'($urandom));
        qy = $signed(16'($urandom));
        span = ($urandom_range(0, 1)) ? 127 : 1023;
        for (int k = 0; k < n_edges; k++)
        begin
            if (close)
            begin
                ax = near_coord(qx, span);
                ay = near_coord(qy, span);
                bx = near_coord(qx, span);
                by = near_coord(qy, span);
            end
            else
            begin
                ax = $signed(16'($urandom));
                ay = $signed(16'($urandom));
                bx = $signed(16'($urandom));
                by = $signed(16'($urandom));
            end
            // Now and then a zero-length edge.
            if ($urandom_range(0, 9) == 0)
            begin
                bx = ax;
                by = ay;
            end
            send_edge(make_edge(qx, qy, ax, ay, bx, by, k == n_edges - 1));
        end
    endtask

    // Let every expected result arrive, then give the block time to finish
    // any edge that does not produce a result.
    task automatic drain_and_settle();
        edge_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_radius(logic [poc_pkg::RAD_W-1:0] value);
        radius_wdata <= value;
        radius_we    <= 1'b1;
        @(posedge clk);
        radius_we    <= 1'b0;
        sb.radius = value;
    endtask

    initial
    begin : stimulus
        logic [poc_pkg::RAD_W-1:0] radii[7];
        int target;
        sb = new();
        rst_n        <= 1'b0;
        edge_valid   <= 1'b0;
        edge_beat    <= '0;
        radius_we    <= 1'b0;
        radius_wdata <= '0;
        quiet        = 0;
        hold_off     = 0;
        edges_sent   = 0;
        queries_sent = 0;
        idle_cycles  = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, run with the reset radius of 64 (0.25 m).
        // Full-scale corners: a zero-length edge and two clamps to an end vertex;
        // the first gives the largest clearance the coordinates can reach.
        send_edge(make_edge(32767, 32767, -32768, -32768, -32768, -32768, 1));
        send_edge(make_edge(-32768, -32768, 32767, 32767, 32767, -32768, 1));
        send_edge(make_edge(-32768, 32767, 32767, -32768, -32768, -32768, 1));
        // Interior projection, then a clamp before the start, then past the end.
        send_edge(make_edge(0, 256, -512, 0, 512, 0, 0));
        send_edge(make_edge(0, 0, 100, 0, 200, 0, 0));
        send_edge(make_edge(0, 0, -200, 0, -100, 0, 1));
        // Rounded projections, with a negative edge direction on y, then on x.
        send_edge(make_edge(3, -7, -100, 37, 91, -55, 1));
        send_edge(make_edge(-1000, 500, 333, -777, -2001, 1999, 1));
        // Clearance exactly zero still counts as a collision.
        send_edge(make_edge(0, 0, 64, 0, 64, 0, 1));
        // Collision on the first edge freezes the value; the far and closer edges
        // after it change nothing.
        send_edge(make_edge(0, 0, 10, 0, 10, 5, 0));
        send_edge(make_edge(0, 0, 30000, 30000, 30001, 30000, 0));
        send_edge(make_edge(0, 0, 0, 0, 0, 1, 0));
        send_edge(make_edge(0, 0, 5000, 5000, 5000, 5000, 1));
        // Query point sitting on the segment gives the most negative clearance.
        send_edge(make_edge(100, 100, 0, 0, 200, 200, 1));
        // A clear query right after a frozen one must start fresh.
        send_edge(make_edge(0, 0, 300, -300, 300, 300, 1));
        // A minimum that is found only on the last of several edges.
        send_edge(make_edge(50, 50, 2000, 0, 3000, 0, 0));
        send_edge(make_edge(50, 50, -900, 40, -900, 900, 0));
        send_edge(make_edge(50, 50, 200, -400, 200, 400, 1));
        drain_and_settle();

        // Random part: phases with different radii, the extremes included.
        radii[0] = '0;
        radii[1] = '1;
        radii[2] = 15'd64;
        radii[3] = 15'd512;
        radii[4] = poc_pkg::RAD_W'($urandom);
        radii[5] = 15'd1;
        radii[6] = poc_pkg::RAD_W'($urandom_range(0, 2047));
        for (int p = 0; p < 7; p++)
        begin
            write_radius(radii[p]);
            quiet = (p % 3 == 2);
            if (p == 3)
            begin
                // Receiver holds off for a long stretch while edges keep coming,
                // so the result register fills and the input stalls.
                fork
                    begin
                        hold_off = 1;
                        repeat (HOLD_SPAN) @(posedge clk);
                        hold_off = 0;
                    end
                join_none
            end
            target = edges_sent + 250;
            while (edges_sent < target)
                run_query($urandom_range(1, 6));
            drain_and_settle();
        end

        quiet = 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (sb.pending.size() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d results never arrived", $time, sb.pending.size());
        end

        $display("Ran %0d edges in %0d queries over 8 radius settings.",
                 edges_sent, queries_sent);
        $display("Checked %0d results, %0d of them collisions, %0d errors.",
                 sb.results_seen, sb.collisions_seen, sb.errors);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
